// ===== rtl/dq_pkg.sv =====
// Package: shared types, operation codes and status codes for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

   // Fixed field widths and default capacity
   localparam int DATA_W    = 32;
   localparam int FUNC_W    = 3;
   localparam int CODE_W    = 2;
   localparam int FILL_W    = 5;
   localparam int DEPTH_DEF = 16;

   // Operation codes carried in the func field
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_STATUS     = 3'd4;

   // Status codes reported with every result
   localparam logic [CODE_W-1:0] CODE_OK        = 2'd0;
   localparam logic [CODE_W-1:0] CODE_OVERFLOW  = 2'd1;
   localparam logic [CODE_W-1:0] CODE_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [CODE_W-1:0]        code;
      logic                     is_empty;
      logic                     is_full;
      logic [FILL_W-1:0]        fill;
   } rsp_type;

   // Broadcast commands from the controller to every cell
   typedef struct packed {
      logic push_back;
      logic push_front;
      logic pop_front;
      logic pop_back;
   } cell_ctl_type;

endpackage

// ===== rtl/dq_cell.sv =====
// One storage cell of the shift chain: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps

module dq_cell
   import dq_pkg::*;
(
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic                     write_sel,
   input  logic                     read_sel,
   input  logic signed [DATA_W-1:0] left_word,
   input  logic signed [DATA_W-1:0] right_word,
   input  logic signed [DATA_W-1:0] push_word,
   output logic signed [DATA_W-1:0] word,
   output logic signed [DATA_W-1:0] read_word
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   // Shift toward the back on push front, toward the front on pop front,
   // load at the tail slot on push back, otherwise hold
   always_comb begin
      priority if (ctl.push_front) begin
         data_in = left_word;
      end else if (ctl.pop_front) begin
         data_in = right_word;
      end else if (ctl.push_back && write_sel) begin
         data_in = push_word;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word      = data_ff;
   // Drive the back-read bus only from the last occupied cell
   assign read_word = read_sel ? data_ff : '0;

endmodule

// ===== rtl/dq_ctrl.sv =====
// Controller: entry count, operation decode, handshake and result register.
`timescale 1ns / 1ps

module dq_ctrl
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp,
   input  logic signed [DATA_W-1:0] front_word,
   input  logic signed [DATA_W-1:0] back_word,
   output cell_ctl_type             ctl,
   output logic [CW-1:0]            count
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [CODE_W-1:0]     code;
   logic [CW+FILL_W-1:0]  fill_ext;

   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Decode the operation; errors leave the cells and count untouched
   always_comb begin
      ctl  = '0;
      code = CODE_OK;
      unique case (req_func)
         FUNC_PUSH_BACK: begin
            ctl.push_back = accept && !full;
            code          = full ? CODE_OVERFLOW : CODE_OK;
         end
         FUNC_PUSH_FRONT: begin
            ctl.push_front = accept && !full;
            code           = full ? CODE_OVERFLOW : CODE_OK;
         end
         FUNC_POP_FRONT: begin
            ctl.pop_front = accept && !empty;
            code          = empty ? CODE_UNDERFLOW : CODE_OK;
         end
         FUNC_POP_BACK: begin
            ctl.pop_back = accept && !empty;
            code         = empty ? CODE_UNDERFLOW : CODE_OK;
         end
         default: begin
            code = CODE_OK;
         end
      endcase
   end

   // Advance the count on a successful push or pop
   always_comb begin
      priority if (ctl.push_back || ctl.push_front) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop_front || ctl.pop_back) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Build the result from the state after the operation
   assign fill_ext = {{FILL_W{1'b0}}, count_in};

   always_comb begin
      rsp_in          = '0;
      rsp_in.data_out = ctl.pop_front ? front_word :
                        ctl.pop_back  ? back_word  : '0;
      rsp_in.code     = code;
      rsp_in.is_empty = (count_in == '0);
      rsp_in.is_full  = (count_in == FULL_COUNT);
      rsp_in.fill     = fill_ext[FILL_W-1:0];
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register on each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign count     = count_ff;

   // Count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // A rejected operation leaves the count as it was
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      accept && code != CODE_OK |=> count_ff == $past(count_ff))
      else $error("count changed on an error");

   // A stalled result is never overwritten by a new item
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !accept)
      else $error("item accepted over a waiting result");

   // Reported flags agree with the count of the result
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.is_empty == (count_ff == '0)
                 && rsp_ff.is_full == (count_ff == FULL_COUNT))
      else $error("result flags disagree with count");

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Top level: double-ended queue built from a row of shifting storage cells.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_type  (func, data_in)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_type  (data_out, code, flags, fill)
//
// One item per cycle while results are drained; each result appears in the output register
// in the cycle after its item is taken. The cells shift the whole row together on push front and
// pop front, so the front is always cell 0 and the back is cell count-1.
// Synchronous reset empties the queue; stored words are not cleared.
// A new item is taken while the result register is empty or being drained.
`timescale 1ns / 1ps

module double_ended_queue_top
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int CW = $clog2(DEPTH + 1);

   cell_ctl_type             ctl;
   logic [CW-1:0]            count;
   logic signed [DATA_W-1:0] cell_word [DEPTH];
   logic signed [DATA_W-1:0] cell_read [DEPTH];
   logic signed [DATA_W-1:0] back_word;

   dq_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req.func),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp),
      .front_word (cell_word[0]),
      .back_word  (back_word),
      .ctl        (ctl),
      .count      (count)
   );

   // Row of cells; cell 0 takes the pushed word on push front
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_word;
      logic signed [DATA_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = req.data_in;
      end else begin : g_mid_l
         assign left_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_r
         assign right_word = cell_word[i+1];
      end

      dq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .write_sel  (count == CW'(i)),
         .read_sel   (count == CW'(i + 1)),
         .left_word  (left_word),
         .right_word (right_word),
         .push_word  (req.data_in),
         .word       (cell_word[i]),
         .read_word  (cell_read[i])
      );
   end

   // Merge the back-read bus; at most one cell drives it
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | cell_read[i];
      end
   end

endmodule

// ===== test/double_ended_queue_checker.sv =====
// Checker: watches both channels of the deque, predicts every result and compares it.
`timescale 1ns / 1ps

module double_ended_queue_checker
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp,
   output int      failures,
   output int      outstanding
);

   localparam int MAX_REPORTS = 10;

   // Shadow copy of the deque contents and pointers
   logic signed [DATA_W-1:0] deque_words [DEPTH];
   int                       front_slot;
   int                       word_count;

   // Results predicted but not yet seen on the output channel
   rsp_type                  expected_results [$];
   int                       mismatch_count = 0;

   // Apply one operation to the shadow deque and build the result it must give
   task automatic predict_result(input req_type item, output rsp_type outcome);
      logic at_capacity;
      logic no_entries;
      outcome     = '0;
      outcome.code = CODE_OK;
      at_capacity = (word_count >= DEPTH);
      no_entries  = (word_count == 0);
      case (item.func)
         FUNC_PUSH_BACK: begin
            if (at_capacity) begin
               outcome.code = CODE_OVERFLOW;
            end else begin
               deque_words[(front_slot + word_count) % DEPTH] = item.data_in;
               word_count++;
            end
         end
         FUNC_PUSH_FRONT: begin
            if (at_capacity) begin
               outcome.code = CODE_OVERFLOW;
            end else begin
               front_slot = (front_slot + DEPTH - 1) % DEPTH;
               deque_words[front_slot] = item.data_in;
               word_count++;
            end
         end
         FUNC_POP_FRONT: begin
            if (no_entries) begin
               outcome.code = CODE_UNDERFLOW;
            end else begin
               outcome.data_out = deque_words[front_slot];
               front_slot = (front_slot + 1) % DEPTH;
               word_count--;
            end
         end
         FUNC_POP_BACK: begin
            if (no_entries) begin
               outcome.code = CODE_UNDERFLOW;
            end else begin
               outcome.data_out = deque_words[(front_slot + word_count - 1) % DEPTH];
               word_count--;
            end
         end
         default: begin
            // status query and spare codes leave the deque alone
         end
      endcase
      outcome.is_empty = (word_count == 0);
      outcome.is_full  = (word_count >= DEPTH);
      outcome.fill     = word_count[FILL_W-1:0];
   endtask

   // Sample both channels at each edge; predict on input, compare on output
   always @(posedge clock) begin
      rsp_type prediction;
      rsp_type oldest;
      if (reset) begin
         front_slot = 0;
         word_count = 0;
         expected_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_result(req, prediction);
            expected_results.push_back(prediction);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result with no item pending:", $time);
                  $display("%0t:   data_out=%0d code=%0d empty=%0b full=%0b fill=%0d",
                           $time, rsp.data_out, rsp.code, rsp.is_empty, rsp.is_full,
                           rsp.fill);
               end
            end else begin
               oldest = expected_results.pop_front();
               if (rsp.data_out !== oldest.data_out || rsp.code !== oldest.code ||
                   rsp.is_empty !== oldest.is_empty || rsp.is_full !== oldest.is_full ||
                   rsp.fill !== oldest.fill) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: mismatch: expected data_out=%0d code=%0d %s",
                              $time, oldest.data_out, oldest.code,
                              $sformatf("empty=%0b full=%0b fill=%0d",
                                        oldest.is_empty, oldest.is_full, oldest.fill));
                     $display("%0t:           actual   data_out=%0d code=%0d %s",
                              $time, rsp.data_out, rsp.code,
                              $sformatf("empty=%0b full=%0b fill=%0d",
                                        rsp.is_empty, rsp.is_full, rsp.fill));
                  end
               end
            end
         end
      end
      failures    = mismatch_count;
      outstanding = expected_results.size();
   end

endmodule

// ===== test/double_ended_queue_top_tb.sv =====
// Testbench top: drives operations into the deque, stalls the result side and gives the verdict.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
   import dq_pkg::*;

   localparam int QUEUE_DEPTH   = DEPTH_DEF;
   localparam int ITEM_TARGET   = 1650;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 4;

   // Spare operation codes; the block must treat them as a status query
   localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = FUNC_STATUS + 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = FUNC_STATUS + 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = FUNC_STATUS + 3'd3;

   localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } op_mix_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   int      failures;
   int      outstanding;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      hold_requests = 0;
   int      cycle_count   = 0;

   double_ended_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   double_ended_queue_checker #(
      .DEPTH(QUEUE_DEPTH)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp),
      .failures   (failures),
      .outstanding(outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort on a hung handshake
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one item, with a random gap ahead of it; return once it is taken
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic signed [DATA_W-1:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req.func    <= func;
      req.data_in <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and hold until every predicted result has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Mostly random words, with the extremes mixed in
   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Choose an operation, leaning toward pushes or pops by the current mix
   function automatic logic [FUNC_W-1:0] pick_func(input op_mix_type mix);
      int push_pct;
      case (mix)
         MIX_FILL:  push_pct = 80;
         MIX_DRAIN: push_pct = 20;
         default:   push_pct = 50;
      endcase
      if ($urandom_range(0, 99) < 8) begin
         case ($urandom_range(0, 3))
            0:       return FUNC_STATUS;
            1:       return FUNC_SPARE_5;
            2:       return FUNC_SPARE_6;
            default: return FUNC_SPARE_7;
         endcase
      end else if ($urandom_range(0, 99) < push_pct) begin
         return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
      end else begin
         return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      end
   endfunction

   // Stimulus and verdict
   initial begin
      int         sent;
      int         block_index;
      int         block_len;
      op_mix_type mix;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow, status and spare codes on an empty deque
      send_item(FUNC_POP_FRONT, WORD_MAX);
      send_item(FUNC_POP_BACK, WORD_MIN);
      send_item(FUNC_STATUS, '1);
      send_item(FUNC_SPARE_5, WORD_MAX);
      send_item(FUNC_SPARE_6, WORD_MIN);
      send_item(FUNC_SPARE_7, '0);

      // Fill to capacity from both ends, then overflow on each end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_item((i % 2 == 0) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
                   (i < 4) ? ((i % 2 == 0) ? WORD_MAX : WORD_MIN) : $urandom);
      end
      send_item(FUNC_PUSH_BACK, WORD_MAX);
      send_item(FUNC_PUSH_FRONT, WORD_MIN);
      send_item(FUNC_STATUS, '0);
      send_item(FUNC_POP_FRONT, '0);
      send_item(FUNC_POP_BACK, '0);

      // Random blocks: each with its own operation mix and idling phase
      sent        = 0;
      block_index = 0;
      while (sent < ITEM_TARGET) begin
         case (block_index % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 54;
            end
            default: begin
               send_idle_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         mix       = op_mix_type'($urandom_range(0, 2));
         block_len = $urandom_range(10, 60);
         if (block_index % 10 == 5) begin
            hold_requests++;
         end
         for (int i = 0; i < block_len; i++) begin
            send_item(pick_func(mix), pick_word());
            sent++;
         end
         if (block_index % 10 == 9) begin
            wait_for_drain();
         end
         block_index++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
